// ----- src/ptom_pkg.sv -----
package ptom_pkg;

    localparam int MAX_RESTING_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_NEW    = 1'b0;
    localparam logic CMD_CANCEL = 1'b1;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    localparam logic [1:0] TIF_GTC    = 2'd0;
    localparam logic [1:0] TIF_IOC    = 2'd1;
    localparam logic [1:0] TIF_MARKET = 2'd2;
    localparam logic [1:0] TIF_FOK    = 2'd3;

    localparam logic [2:0] EV_ACK     = 3'd0;
    localparam logic [2:0] EV_TRADE   = 3'd1;
    localparam logic [2:0] EV_CANCEL  = 3'd2;
    localparam logic [2:0] EV_STP     = 3'd3;
    localparam logic [2:0] EV_REJECT  = 3'd4;
    localparam logic [2:0] EV_EXPIRED = 3'd5;

    localparam logic [1:0] RR_NONE      = 2'd0;
    localparam logic [1:0] RR_FOK       = 2'd1;
    localparam logic [1:0] RR_UNKNOWN   = 2'd2;
    localparam logic [1:0] RR_BOOK_FULL = 2'd3;

    typedef struct packed {
        logic               command;
        logic [63:0]        sequence_req;
        logic [15:0]        session;
        logic [63:0]        order_id;
        logic [15:0]        firm;
        logic               side;
        logic [1:0]         time_in_force;
        logic signed [31:0] limit_price;
        logic [31:0]        quantity;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         event_kind;
        logic [63:0]        event_sequence;
        logic               event_side;
        logic signed [31:0] event_price;
        logic [31:0]        event_quantity;
        logic [1:0]         reject_reason;
        logic [15:0]        resting_session;
        logic [63:0]        resting_order_id;
        logic [15:0]        aggressor_session;
        logic [63:0]        aggressor_order_id;
        logic               last_event;
    } out_item_t;

    typedef struct packed {
        logic is_cancel;
        logic is_fok;
        logic is_market;
        logic rests;
        logic expires;
    } cls_t;

    typedef struct packed {
        in_item_t item;
        cls_t     cls;
    } q_entry_t;

    function automatic out_item_t mk_event(
        input logic [2:0]         kind,
        input logic [63:0]        seq,
        input logic               side,
        input logic signed [31:0] price,
        input logic [31:0]        qty,
        input logic [1:0]         reason,
        input logic [15:0]        rs,
        input logic [63:0]        rid,
        input logic [15:0]        ag_s,
        input logic [63:0]        ag_id
    );
        out_item_t e;
        e.event_kind         = kind;
        e.event_sequence     = seq;
        e.event_side         = side;
        e.event_price        = price;
        e.event_quantity     = qty;
        e.reject_reason      = reason;
        e.resting_session    = rs;
        e.resting_order_id   = rid;
        e.aggressor_session  = ag_s;
        e.aggressor_order_id = ag_id;
        e.last_event         = 1'b0;
        return e;
    endfunction

endpackage

// ----- src/ptom_front.sv -----
module ptom_front import ptom_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  in_item_t request,
    input  logic     pop,
    output q_entry_t head,
    output logic     empty
);

    q_entry_t           q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  cnt_reg;
    logic               push;
    cls_t               cls;

    assign busy  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign push  = start && !busy;
    assign head  = q_reg[rd_ptr_reg];

    // Work out once what the back end has to do with the order.
    always_comb
    begin
        cls.is_cancel = (request.command == CMD_CANCEL);
        cls.is_fok    = (request.command == CMD_NEW) && (request.time_in_force == TIF_FOK);
        cls.is_market = (request.time_in_force == TIF_MARKET);
        cls.rests     = (request.time_in_force == TIF_GTC);
        cls.expires   = (request.time_in_force == TIF_IOC) ||
                        (request.time_in_force == TIF_MARKET);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg].item <= request;
            q_reg[wr_ptr_reg].cls  <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ----- src/ptom_back.sv -----
module ptom_back import ptom_pkg::*;
#(
    parameter int MAX_RESTING = MAX_RESTING_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_entry_t  head,
    input  logic      empty,
    output logic      pop,
    output logic      result_valid,
    output out_item_t result
);

    localparam int IDX_W = (MAX_RESTING > 1) ? $clog2(MAX_RESTING) : 1;
    localparam int CNT_W = $clog2(MAX_RESTING + 1);
    localparam int SUM_W = 32 + CNT_W;

    localparam logic [1:0] MODE_CXL  = 2'd0;
    localparam logic [1:0] MODE_SUM  = 2'd1;
    localparam logic [1:0] MODE_BEST = 2'd2;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_TAIL   = 7'b0001000,
        S_FREE   = 7'b0010000,
        S_REST   = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    // Order book storage.
    logic               mem_side  [MAX_RESTING];
    logic signed [31:0] mem_price [MAX_RESTING];
    logic [31:0]        mem_rem   [MAX_RESTING];
    logic [15:0]        mem_firm  [MAX_RESTING];
    logic [15:0]        mem_sess  [MAX_RESTING];
    logic [63:0]        mem_oid   [MAX_RESTING];
    logic [31:0]        mem_arr   [MAX_RESTING];

    logic               rd_side;
    logic signed [31:0] rd_price;
    logic [31:0]        rd_rem;
    logic [15:0]        rd_firm;
    logic [15:0]        rd_sess;
    logic [63:0]        rd_oid;
    logic [31:0]        rd_arr;
    logic [IDX_W-1:0]   rd_addr;

    logic               we_rem;
    logic               we_all;
    logic [IDX_W-1:0]   wr_addr;
    logic [31:0]        wr_rem;

    state_t                   state_reg, state_next;
    logic [MAX_RESTING-1:0]   valid_reg, valid_next;
    logic [31:0]              counter_reg, counter_next;
    logic [1:0]               mode_reg, mode_next;
    logic [CNT_W-1:0]         scan_reg, scan_next;
    logic                     p_valid_reg, p_valid_next;
    logic [IDX_W-1:0]         p_idx_reg, p_idx_next;
    logic                     found_reg, found_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [IDX_W-1:0]         free_reg, free_next;
    logic [31:0]              rem_reg, rem_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic                     out_valid_reg, out_valid_next;

    q_entry_t                 cur_reg, cur_next;
    logic [IDX_W-1:0]         best_idx_reg, best_idx_next;
    logic                     best_side_reg, best_side_next;
    logic signed [31:0]       best_price_reg, best_price_next;
    logic [31:0]              best_age_reg, best_age_next;
    logic [31:0]              best_rem_reg, best_rem_next;
    logic [15:0]              best_firm_reg, best_firm_next;
    logic [15:0]              best_sess_reg, best_sess_next;
    logic [63:0]              best_oid_reg, best_oid_next;
    out_item_t                pend_reg, pend_next;
    out_item_t                out_reg, out_next;

    logic                     ev_fire;
    out_item_t                ev;
    logic                     fin;

    logic [31:0]              age_rd;
    logic                     price_ok;
    logic                     hit;
    logic                     elig_opp;
    logic                     better_best;
    logic                     better_cxl;
    logic                     take;
    logic                     add_sum;
    logic [31:0]              trade_q;

    assign rd_addr      = scan_reg[IDX_W-1:0];
    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    always_ff @(posedge clk)
    begin
        rd_side  <= mem_side[rd_addr];
        rd_price <= mem_price[rd_addr];
        rd_rem   <= mem_rem[rd_addr];
        rd_firm  <= mem_firm[rd_addr];
        rd_sess  <= mem_sess[rd_addr];
        rd_oid   <= mem_oid[rd_addr];
        rd_arr   <= mem_arr[rd_addr];
        if (we_rem)
            mem_rem[wr_addr] <= wr_rem;
        if (we_all)
        begin
            mem_side[wr_addr]  <= cur_reg.item.side;
            mem_price[wr_addr] <= cur_reg.item.limit_price;
            mem_firm[wr_addr]  <= cur_reg.item.firm;
            mem_sess[wr_addr]  <= cur_reg.item.session;
            mem_oid[wr_addr]   <= cur_reg.item.order_id;
            mem_arr[wr_addr]   <= counter_reg;
        end
    end

    // Compare stage of the scan, one slot per cycle.
    always_comb
    begin
        age_rd   = counter_reg - rd_arr;
        price_ok = cur_reg.cls.is_market ||
                   ((cur_reg.item.side == SIDE_BUY) ?
                    ($signed(rd_price) <= $signed(cur_reg.item.limit_price)) :
                    ($signed(rd_price) >= $signed(cur_reg.item.limit_price)));
        hit      = p_valid_reg && valid_reg[p_idx_reg];
        elig_opp = hit && (rd_side != cur_reg.item.side) && price_ok;
        better_best = !found_reg ||
                      ((cur_reg.item.side == SIDE_BUY) ?
                       ($signed(rd_price) < $signed(best_price_reg)) :
                       ($signed(rd_price) > $signed(best_price_reg))) ||
                      ((rd_price == best_price_reg) && (age_rd > best_age_reg));
        better_cxl = !found_reg || (age_rd > best_age_reg);
        take     = 1'b0;
        case (mode_reg)
            MODE_CXL:  take = hit && (rd_sess == cur_reg.item.session) &&
                              (rd_oid == cur_reg.item.order_id) && better_cxl;
            MODE_BEST: take = elig_opp && better_best;
            default:   take = 1'b0;
        endcase
        add_sum  = (mode_reg == MODE_SUM) && elig_opp && (rd_firm != cur_reg.item.firm);
        trade_q  = (rem_reg < best_rem_reg) ? rem_reg : best_rem_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        counter_next    = counter_reg;
        mode_next       = mode_reg;
        scan_next       = scan_reg;
        p_valid_next    = p_valid_reg;
        p_idx_next      = p_idx_reg;
        found_next      = found_reg;
        sum_next        = sum_reg;
        free_next       = free_reg;
        rem_next        = rem_reg;
        cur_next        = cur_reg;
        best_idx_next   = best_idx_reg;
        best_side_next  = best_side_reg;
        best_price_next = best_price_reg;
        best_age_next   = best_age_reg;
        best_rem_next   = best_rem_reg;
        best_firm_next  = best_firm_reg;
        best_sess_next  = best_sess_reg;
        best_oid_next   = best_oid_reg;
        pop             = 1'b0;
        ev_fire         = 1'b0;
        ev              = '0;
        fin             = 1'b0;
        we_rem          = 1'b0;
        we_all          = 1'b0;
        wr_addr         = best_idx_reg;
        wr_rem          = best_rem_reg - trade_q;

        case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop          = 1'b1;
                    cur_next     = head;
                    rem_next     = head.item.quantity;
                    scan_next    = '0;
                    p_valid_next = 1'b0;
                    found_next   = 1'b0;
                    sum_next     = '0;
                    if (head.cls.is_cancel)
                    begin
                        mode_next  = MODE_CXL;
                        state_next = S_SCAN;
                    end
                    else if (head.cls.is_fok)
                    begin
                        mode_next  = MODE_SUM;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        ev_fire    = 1'b1;
                        ev         = mk_event(EV_ACK, head.item.sequence_req, head.item.side,
                                              head.item.limit_price, '0, RR_NONE, '0, '0,
                                              head.item.session, head.item.order_id);
                        mode_next  = MODE_BEST;
                        state_next = (head.item.quantity == '0) ? S_DONE : S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (scan_reg != CNT_W'(MAX_RESTING))
                begin
                    scan_next    = scan_reg + 1'b1;
                    p_valid_next = 1'b1;
                    p_idx_next   = scan_reg[IDX_W-1:0];
                end
                else
                begin
                    p_valid_next = 1'b0;
                end
                if (take)
                begin
                    found_next      = 1'b1;
                    best_idx_next   = p_idx_reg;
                    best_side_next  = rd_side;
                    best_price_next = rd_price;
                    best_age_next   = age_rd;
                    best_rem_next   = rd_rem;
                    best_firm_next  = rd_firm;
                    best_sess_next  = rd_sess;
                    best_oid_next   = rd_oid;
                end
                if (add_sum)
                    sum_next = sum_reg + SUM_W'(rd_rem);
                if ((scan_reg == CNT_W'(MAX_RESTING)) && !p_valid_reg)
                    state_next = S_DECIDE;
            end

            S_DECIDE:
            begin
                // A following scan restarts from the first slot.
                scan_next    = '0;
                p_valid_next = 1'b0;
                found_next   = 1'b0;
                case (mode_reg)
                    MODE_CXL:
                    begin
                        ev_fire = 1'b1;
                        if (found_reg)
                        begin
                            valid_next[best_idx_reg] = 1'b0;
                            ev = mk_event(EV_CANCEL, cur_reg.item.sequence_req, best_side_reg,
                                          '0, best_rem_reg, RR_NONE, best_sess_reg,
                                          best_oid_reg, cur_reg.item.session,
                                          cur_reg.item.order_id);
                        end
                        else
                        begin
                            ev = mk_event(EV_REJECT, cur_reg.item.sequence_req, SIDE_BUY,
                                          '0, '0, RR_UNKNOWN, '0, '0, cur_reg.item.session,
                                          cur_reg.item.order_id);
                        end
                        state_next = S_DONE;
                    end
                    MODE_SUM:
                    begin
                        ev_fire = 1'b1;
                        if (sum_reg < SUM_W'(cur_reg.item.quantity))
                        begin
                            ev = mk_event(EV_REJECT, cur_reg.item.sequence_req,
                                          cur_reg.item.side, '0, '0, RR_FOK, '0, '0,
                                          cur_reg.item.session, cur_reg.item.order_id);
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ev = mk_event(EV_ACK, cur_reg.item.sequence_req,
                                          cur_reg.item.side, cur_reg.item.limit_price, '0,
                                          RR_NONE, '0, '0, cur_reg.item.session,
                                          cur_reg.item.order_id);
                            mode_next  = MODE_BEST;
                            state_next = (rem_reg == '0) ? S_DONE : S_SCAN;
                        end
                    end
                    default:
                    begin
                        if (!found_reg)
                        begin
                            state_next = S_TAIL;
                        end
                        else if (best_firm_reg == cur_reg.item.firm)
                        begin
                            // Same firm on the other side: cancel it instead of trading.
                            ev_fire = 1'b1;
                            valid_next[best_idx_reg] = 1'b0;
                            ev = mk_event(EV_STP, cur_reg.item.sequence_req,
                                          cur_reg.item.side, '0, best_rem_reg, RR_NONE,
                                          best_sess_reg, best_oid_reg, cur_reg.item.session,
                                          cur_reg.item.order_id);
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            ev_fire = 1'b1;
                            ev = mk_event(EV_TRADE, cur_reg.item.sequence_req,
                                          cur_reg.item.side, best_price_reg, trade_q, RR_NONE,
                                          best_sess_reg, best_oid_reg, cur_reg.item.session,
                                          cur_reg.item.order_id);
                            we_rem = 1'b1;
                            if (best_rem_reg == trade_q)
                                valid_next[best_idx_reg] = 1'b0;
                            rem_next   = rem_reg - trade_q;
                            state_next = (rem_reg == trade_q) ? S_TAIL : S_SCAN;
                        end
                    end
                endcase
            end

            S_TAIL:
            begin
                free_next = '0;
                if (rem_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (cur_reg.cls.rests)
                begin
                    state_next = S_FREE;
                end
                else if (cur_reg.cls.expires)
                begin
                    ev_fire = 1'b1;
                    ev = mk_event(EV_EXPIRED, cur_reg.item.sequence_req, cur_reg.item.side,
                                  '0, rem_reg, RR_NONE, '0, '0, cur_reg.item.session,
                                  cur_reg.item.order_id);
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_FREE:
            begin
                if (!valid_reg[free_reg])
                begin
                    state_next = S_REST;
                end
                else if (free_reg == IDX_W'(MAX_RESTING - 1))
                begin
                    ev_fire = 1'b1;
                    ev = mk_event(EV_REJECT, cur_reg.item.sequence_req, cur_reg.item.side,
                                  '0, rem_reg, RR_BOOK_FULL, '0, '0, cur_reg.item.session,
                                  cur_reg.item.order_id);
                    state_next = S_DONE;
                end
                else
                begin
                    free_next = free_reg + 1'b1;
                end
            end

            S_REST:
            begin
                wr_addr              = free_reg;
                wr_rem               = rem_reg;
                we_rem               = 1'b1;
                we_all               = 1'b1;
                valid_next[free_reg] = 1'b1;
                counter_next         = counter_reg + 1'b1;
                state_next           = S_DONE;
            end

            S_DONE:
            begin
                fin        = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Each result is held back one step so that the final one can be marked.
    always_comb
    begin
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = 1'b0;
        if (ev_fire)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_valid_next = 1'b1;
            end
            pend_next       = ev;
            pend_valid_next = 1'b1;
        end
        else if (fin)
        begin
            out_next            = pend_reg;
            out_next.last_event = 1'b1;
            out_valid_next      = 1'b1;
            pend_valid_next     = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        best_idx_reg   <= best_idx_next;
        best_side_reg  <= best_side_next;
        best_price_reg <= best_price_next;
        best_age_reg   <= best_age_next;
        best_rem_reg   <= best_rem_next;
        best_firm_reg  <= best_firm_next;
        best_sess_reg  <= best_sess_next;
        best_oid_reg   <= best_oid_next;
        pend_reg       <= pend_next;
        out_reg        <= out_next;
        rem_reg        <= rem_next;
        sum_reg        <= sum_next;
        p_idx_reg      <= p_idx_next;
        free_reg       <= free_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            counter_reg    <= '0;
            mode_reg       <= MODE_CXL;
            scan_reg       <= '0;
            p_valid_reg    <= 1'b0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            counter_reg    <= counter_next;
            mode_reg       <= mode_next;
            scan_reg       <= scan_next;
            p_valid_reg    <= p_valid_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

// ----- src/price_time_order_matching.sv -----
// Limit order book with price-time priority matching.
// An order or cancel beat is taken on the request port when start is high and
// busy is low. A two-entry queue sits in front of the matching engine, so busy
// only rises when two beats are waiting behind the one being worked on.
// Each input gives one or more result beats on the result port, one cycle each,
// marked by result_valid; last_event marks the final beat of an input.
// Every search of the book is a scan of the slot memory, one slot per cycle.
// A cancel takes one scan; a new order takes one scan per trade or
// self-trade cancel plus one final scan unless a trade fills it, a second
// scan more for FOK, and a search of the slots for a free one when a GTC
// remainder rests. Reset empties the book and zeroes the arrival counter;
// no clearing pass is needed. The receiver cannot stall: result beats are
// produced at most one per cycle and are not held.
module price_time_order_matching import ptom_pkg::*;
#(
    parameter int MAX_RESTING = MAX_RESTING_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  request,
    output logic      result_valid,
    output out_item_t result
);

    q_entry_t head;
    logic     empty;
    logic     pop;

    ptom_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .pop     (pop),
        .head    (head),
        .empty   (empty)
    );

    ptom_back #(.MAX_RESTING(MAX_RESTING)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ----- src/ptom_checker.sv -----
module ptom_checker import ptom_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      result_valid,
    input out_item_t result
);

    // A reason code appears on rejects and nowhere else.
    a_reason: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.event_kind == EV_REJECT) ==
                          (result.reject_reason != RR_NONE)))
        else $error("reject reason does not match event kind");

    a_trade_qty: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.event_kind == EV_TRADE)) |-> (result.event_quantity != '0))
        else $error("trade of zero quantity");

    a_price_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.event_kind != EV_ACK) && (result.event_kind != EV_TRADE))
        |-> (result.event_price == '0))
        else $error("price set on a result that carries none");

    // The engine leaves a gap with no result beat between the last beat of one
    // input and the first beat of the next.
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_event) |=> !result_valid)
        else $error("result beat straight after a final beat");

endmodule

bind price_time_order_matching ptom_checker u_ptom_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result       (result)
);
